/* rtl/core/cfr_pkg.sv */
// package for the command frame receiver: widths, codes and the result record
// no dependencies; imported by cfr_result_fifo, command_frame_receiver and its testbench
package cfr_pkg;

  localparam int MAX_PAYLOAD = 8;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 4;
  localparam int HDR_LEN     = 4;
  localparam int IDX_W       = 3;

  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd50000;
  localparam logic [7:0]  ACK_BYTE         = 8'd128;
  localparam logic [7:0]  NACK_BYTE        = 8'd0;

  // apb register map
  localparam logic [2:0] ADDR_IDLE_LIMIT = 3'd0;

  typedef enum logic [1:0] {
    OUT_REPLY   = 2'd0,
    OUT_RECORD  = 2'd1,
    OUT_PAYLOAD = 2'd2
  } out_kind_e;

  typedef enum logic {
    PH_HEADER  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_e;

  typedef enum logic [1:0] {
    EM_IDLE    = 2'd0,
    EM_RECORD  = 2'd1,
    EM_PAYLOAD = 2'd2
  } emit_e;

  typedef struct packed {
    out_kind_e        out_kind;
    logic [7:0]       reply_byte;
    logic [7:0]       group_id;
    logic [7:0]       command_code;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       header_checksum;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic             last;
  } result_t;

endpackage

/* rtl/core/cfr_result_fifo.sv */
// two-entry result queue between the frame logic and the output stream
// depends on cfr_pkg for result_t
module cfr_result_fifo import cfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    valid_o,
  output result_t data_o,
  input  logic    pop_i
);

  result_t    entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i && valid_o) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i && valid_o})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/command_frame_receiver.sv */
// top level of the command frame receiver: header check, payload memory, result sequencer
// depends on cfr_pkg and cfr_result_fifo
//
// Receives command frames one input transaction at a time, each a byte (tuser 0) or
// an idle tick (tuser 1). A frame is a 4-byte header (group, command, length, additive
// checksum of the first three bytes), answered by ACK (128) or NACK (0), then the
// payload and its checksum byte. On a good payload the block sends ACK, a command
// record and the payload bytes, tlast on the final one. Lengths above MAX_PAYLOAD are
// refused with NACK; more than header_idle_limit idle ticks during header collection
// discard a partial header. Rate: one input transaction per clock while no multi-result
// run is in progress and the result queue has room; a transaction that gives one result
// or none does not hold input off, and the two-entry result queue lets input continue
// while a result waits. A transaction that completes a frame holds input off while the
// record and then each payload byte go out, one per cycle while the queue has room,
// each byte read from the payload memory through its single registered read port.
module command_frame_receiver import cfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] reply_byte, [15:8] group_id,
                                      // [23:16] command_code, [27:24] payload_length,
                                      // [35:28] header_checksum, [43:36] payload_byte,
                                      // [46:44] payload_index, [47] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration register
  logic [15:0] idle_limit_q;

  // frame state
  phase_e            phase_q, phase_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        sum_q, sum_d;
  logic [15:0]       idle_q, idle_d;
  logic [7:0]        hdr_q [HDR_LEN];

  // result sequencer
  emit_e             emit_q, emit_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  // payload memory
  logic [7:0]        pay_mem [MAX_PAYLOAD];
  logic [7:0]        rd_data_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  // header byte write
  logic              hdr_we;
  logic [1:0]        hdr_waddr;

  // step and sequencer pushes into the result queue
  logic              step_push, em_push, fifo_push, fifo_full, fifo_valid;
  result_t           step_res, em_res, fifo_res, fifo_out;

  logic              accept, busy, is_idle;
  logic [7:0]        rx;
  logic [15:0]       idle_inc;
  logic [LEN_W-1:0]  cnt_inc, size;

  assign is_idle = s_axis_tuser;
  assign rx      = s_axis_tdata;
  assign busy    = (emit_q != EM_IDLE);
  assign s_axis_tready = !busy && !fifo_full;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign size    = hdr_q[2][LEN_W-1:0];

  // apb: always ready, single register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_IDLE_LIMIT) ? {16'd0, idle_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= IDLE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_IDLE_LIMIT)) begin
      idle_limit_q <= pwdata[15:0];
    end
  end

  // per-item frame logic
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    idle_d    = idle_q;
    hdr_we    = 1'b0;
    hdr_waddr = cnt_q[1:0];
    mem_we    = 1'b0;
    mem_waddr = cnt_q[ADDR_W-1:0];
    step_push = 1'b0;
    step_res  = '0;
    emit_d    = emit_q;
    idle_inc  = idle_q + 16'd1;
    cnt_inc   = cnt_q + 1'b1;

    if (accept) begin
      if (phase_q == PH_HEADER) begin
        if (is_idle) begin
          idle_d = idle_inc;
        end else begin
          hdr_we = 1'b1;
          if (cnt_q < LEN_W'(HDR_LEN - 1)) begin
            sum_d = sum_q + rx;
          end
          cnt_d = cnt_inc;
        end
        if (idle_d > idle_limit_q) begin
          // timeout drops the partial header, the new byte included
          cnt_d  = '0;
          sum_d  = '0;
          idle_d = '0;
        end else if (cnt_d == LEN_W'(HDR_LEN)) begin
          // fourth byte is the checksum, compared against the first three
          step_push           = 1'b1;
          step_res.out_kind   = OUT_REPLY;
          step_res.last       = 1'b1;
          if (sum_q != rx || hdr_q[2] > 8'(MAX_PAYLOAD)) begin
            step_res.reply_byte = NACK_BYTE;
            cnt_d  = '0;
            sum_d  = '0;
            idle_d = '0;
          end else if (hdr_q[2] == 8'd0) begin
            // empty payload: record follows the ack right away
            step_res.reply_byte = ACK_BYTE;
            step_res.last       = 1'b0;
            emit_d = EM_RECORD;
            cnt_d  = '0;
            sum_d  = '0;
            idle_d = '0;
          end else begin
            step_res.reply_byte = ACK_BYTE;
            phase_d = PH_PAYLOAD;
            cnt_d   = '0;
            sum_d   = '0;
            idle_d  = '0;
          end
        end
      end else if (!is_idle) begin
        if (cnt_q < size) begin
          mem_we = 1'b1;
          sum_d  = sum_q + rx;
          cnt_d  = cnt_inc;
        end else if (sum_q != rx) begin
          step_push           = 1'b1;
          step_res.out_kind   = OUT_REPLY;
          step_res.reply_byte = NACK_BYTE;
          step_res.last       = 1'b1;
          cnt_d = '0;
          sum_d = '0;
        end else begin
          step_push           = 1'b1;
          step_res.out_kind   = OUT_REPLY;
          step_res.reply_byte = ACK_BYTE;
          emit_d  = EM_RECORD;
          phase_d = PH_HEADER;
          cnt_d   = '0;
          sum_d   = '0;
          idle_d  = '0;
        end
      end
    end

    // sequencer next state
    unique case (emit_q)
      EM_IDLE: begin
      end
      EM_RECORD: begin
        if (!fifo_full) begin
          emit_d = (size == '0) ? EM_IDLE : EM_PAYLOAD;
        end
      end
      EM_PAYLOAD: begin
        if (!fifo_full && ({1'b0, idx_q} == size - 1'b1)) begin
          emit_d = EM_IDLE;
        end
      end
      default: emit_d = EM_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    em_push = 1'b0;
    em_res  = '0;
    idx_d   = idx_q;
    unique case (emit_q)
      EM_IDLE: begin
      end
      EM_RECORD: begin
        em_push                = !fifo_full;
        em_res.out_kind        = OUT_RECORD;
        em_res.group_id        = hdr_q[0];
        em_res.command_code    = hdr_q[1];
        em_res.payload_length  = size;
        em_res.header_checksum = hdr_q[3];
        em_res.last            = (size == '0);
        idx_d                  = '0;
      end
      EM_PAYLOAD: begin
        em_push              = !fifo_full;
        em_res.out_kind      = OUT_PAYLOAD;
        em_res.payload_byte  = rd_data_q;
        em_res.payload_index = IDX_W'(idx_q);
        em_res.last          = ({1'b0, idx_q} == size - 1'b1);
        if (!fifo_full) begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // input is held off during a run, so the two sources never push together
  assign fifo_push = step_push || em_push;
  assign fifo_res  = em_push ? em_res : step_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      sum_q   <= '0;
      idle_q  <= '0;
      emit_q  <= EM_IDLE;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      idle_q  <= idle_d;
      emit_q  <= emit_d;
      idx_q   <= idx_d;
    end
  end

  // header bytes, written before they are read
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_waddr] <= rx;
    end
  end

  // payload memory, one write port and one registered read port; the read
  // address follows the next sequencer index so data is ready when its turn comes
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pay_mem[mem_waddr] <= rx;
    end
    rd_data_q <= pay_mem[idx_d];
  end

  cfr_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_res),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .data_o      (fifo_out),
    .pop_i       (m_axis_tready)
  );

  assign m_axis_tvalid = fifo_valid;
  assign m_axis_tuser  = fifo_out.out_kind;
  assign m_axis_tlast  = fifo_out.last;
  assign m_axis_tdata  = {1'b0, fifo_out.payload_index, fifo_out.payload_byte,
                          fifo_out.header_checksum, fifo_out.payload_length,
                          fifo_out.command_code, fifo_out.group_id, fifo_out.reply_byte};

`ifndef SYNTHESIS
  // a run always starts from header collection
  a_run_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_q != EM_IDLE) |-> (phase_q == PH_HEADER))
    else $error("result run while collecting payload");

  // payload phase only with an accepted, non-empty length
  a_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (size != '0 && hdr_q[2] <= 8'(MAX_PAYLOAD)))
    else $error("payload phase with bad length");

  // payload indices stay inside the frame
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_q == EM_PAYLOAD) |-> ({1'b0, idx_q} < size))
    else $error("payload index past length");

  // a record is followed by payload output unless it closes the run
  a_record_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_push && emit_q == EM_RECORD && size != '0) |=> (emit_q == EM_PAYLOAD && idx_q == '0))
    else $error("record not followed by payload bytes");
`endif

endmodule

/* tb/sv/command_frame_receiver_tb.sv */
// self-checking testbench for command_frame_receiver: frame stimulus, a cycle-free frame
// predictor, and a field-by-field comparison of every result transaction
// depends on cfr_pkg and the command_frame_receiver rtl
module command_frame_receiver_tb;
  import cfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // predictor state, one copy follows accepted input, one runs ahead for generation
  typedef struct packed {
    phase_e                      ph;
    logic [3:0]                  cnt;
    logic [3:0][7:0]             hdr;
    logic [MAX_PAYLOAD-1:0][7:0] pay;
    logic [7:0]                  sum;
    logic [15:0]                 idle;
    logic [15:0]                 limit;
  } rx_state_t;

  typedef struct packed {
    rx_state_t                     st;
    logic [3:0]                    n;
    result_t [MAX_PAYLOAD+1:0]     r;
  } rx_step_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  rx_item_t  rx_queue [$];
  result_t   pending_results [$];
  rx_state_t rx_model;
  rx_state_t gen_shadow;
  rx_item_t  cur_item;
  bit        offered = 1'b0;
  bit        in_taken = 1'b0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  int        gap_cnt = 0;
  int        stall_cnt = 0;
  int        hold_cnt = 0;
  int        errors = 0;
  int        rx_total = 0;

  command_frame_receiver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // frame predictor
  // ---------------------------------------------------------------------------

  function automatic rx_state_t restart_header(rx_state_t s);
    s.ph   = PH_HEADER;
    s.cnt  = '0;
    s.sum  = '0;
    s.idle = '0;
    return s;
  endfunction

  function automatic result_t reply_result(logic [7:0] code);
    result_t r;
    r            = '0;
    r.out_kind   = OUT_REPLY;
    r.reply_byte = code;
    r.last       = 1'b1;
    return r;
  endfunction

  // ack, command record, then every stored payload byte
  function automatic rx_step_t add_frame(rx_step_t o, int unsigned plen);
    result_t r;
    r      = reply_result(ACK_BYTE);
    r.last = 1'b0;
    o.r[o.n] = r;
    o.n++;
    r                 = '0;
    r.out_kind        = OUT_RECORD;
    r.group_id        = o.st.hdr[0];
    r.command_code    = o.st.hdr[1];
    r.payload_length  = o.st.hdr[2][LEN_W-1:0];
    r.header_checksum = o.st.hdr[3];
    r.last            = (plen == 0);
    o.r[o.n] = r;
    o.n++;
    for (int i = 0; i < plen; i++) begin
      r               = '0;
      r.out_kind      = OUT_PAYLOAD;
      r.payload_byte  = o.st.pay[i];
      r.payload_index = IDX_W'(i);
      r.last          = (i + 1 == plen);
      o.r[o.n] = r;
      o.n++;
    end
    return o;
  endfunction

  function automatic rx_step_t frame_step(rx_state_t s, logic idle_tick, logic [7:0] b);
    rx_step_t   o;
    logic [7:0] plen;
    o    = '0;
    o.st = s;
    plen = s.hdr[2];
    if (s.ph == PH_HEADER) begin
      if (idle_tick) begin
        o.st.idle = s.idle + 16'd1;   // wraps, and survives later bytes
      end else begin
        o.st.hdr[s.cnt[1:0]] = b;
        if (s.cnt < 3) o.st.sum = s.sum + b;
        o.st.cnt = s.cnt + 4'd1;
      end
      plen = o.st.hdr[2];
      if (o.st.idle > o.st.limit) begin
        // partial header dropped silently, a byte just taken included
        o.st = restart_header(o.st);
      end else if (o.st.cnt == HDR_LEN) begin
        if (o.st.sum != o.st.hdr[3] || plen > MAX_PAYLOAD) begin
          o.st   = restart_header(o.st);
          o.r[0] = reply_result(NACK_BYTE);
          o.n    = 1;
        end else if (plen == 0) begin
          o.st = restart_header(o.st);
          o    = add_frame(o, 0);
        end else begin
          o.st      = restart_header(o.st);
          o.st.ph   = PH_PAYLOAD;
          o.r[0]    = reply_result(ACK_BYTE);
          o.n       = 1;
        end
      end
    end else if (!idle_tick) begin
      // idle ticks are dropped while the payload is collected
      if (s.cnt < plen) begin
        o.st.pay[s.cnt[2:0]] = b;
        o.st.sum = s.sum + b;
        o.st.cnt = s.cnt + 4'd1;
      end else if (s.sum != b) begin
        o.st.cnt = '0;
        o.st.sum = '0;
        o.r[0]   = reply_result(NACK_BYTE);
        o.n      = 1;
      end else begin
        o.st = restart_header(o.st);
        o    = add_frame(o, plen);
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation, the shadow copy says where the block will be
  // ---------------------------------------------------------------------------

  task automatic add_rx(logic kind, logic [7:0] data);
    rx_step_t st;
    st         = frame_step(gen_shadow, kind, data);
    gen_shadow = st.st;
    rx_queue.push_back('{kind: kind, data: data});
    rx_total++;
  endtask

  function automatic logic [7:0] rand_byte();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // bring the shadow back to an empty header, finishing a payload if one is open
  task automatic close_frame();
    while (gen_shadow.ph != PH_HEADER || gen_shadow.cnt != 0) begin
      if (gen_shadow.ph == PH_PAYLOAD && gen_shadow.cnt >= gen_shadow.hdr[2])
        add_rx(1'b0, gen_shadow.sum);
      else
        add_rx(1'b0, 8'($urandom));
    end
  endtask

  task automatic gen_frame();
    logic [7:0] hb [4];
    int         k;
    close_frame();
    if ($urandom_range(0, 99) < 6) begin
      // noise: loose bytes and idle ticks
      repeat ($urandom_range(1, 6)) add_rx(1'($urandom), 8'($urandom));
      return;
    end
    hb[0] = rand_byte();
    hb[1] = rand_byte();
    k = $urandom_range(0, 99);
    if (k < 80)      hb[2] = 8'($urandom_range(0, MAX_PAYLOAD));
    else if (k < 92) hb[2] = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
    else             hb[2] = 8'd0;
    hb[3] = hb[0] + hb[1] + hb[2];
    if ($urandom_range(0, 99) < 12) hb[3] = hb[3] + 8'($urandom_range(1, 255));
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) add_rx(1'b1, 8'($urandom));
      add_rx(1'b0, hb[k]);
    end
    // payload attempts until one passes its checksum
    while (gen_shadow.ph == PH_PAYLOAD) begin
      while (gen_shadow.cnt < gen_shadow.hdr[2]) begin
        if ($urandom_range(0, 9) == 0) add_rx(1'b1, 8'($urandom));
        add_rx(1'b0, rand_byte());
      end
      if ($urandom_range(0, 4) == 0)
        add_rx(1'b0, gen_shadow.sum + 8'($urandom_range(1, 255)));
      else
        add_rx(1'b0, gen_shadow.sum);
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: one item offered at a time, random gaps between transactions
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        offered  = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) gap_cnt = $urandom_range(1, 8);
      end
      if (!offered) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
        end else if (rx_queue.size() != 0) begin
          cur_item = rx_queue.pop_front();
          offered  = 1'b1;
        end
      end
      s_axis_tvalid <= offered;
      if (offered) begin
        s_axis_tdata <= cur_item.data;
        s_axis_tuser <= cur_item.kind;
      end
    end
  end

  // result side ready: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 90;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_cnt = $urandom_range(1, 8);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // predictor and result checker, both on the rising edge
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors < 100)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    rx_step_t st;
    result_t  e;
    if (rst_ni) begin
      // predict first so a same-edge result would still find its expectation
      if (s_axis_tvalid && s_axis_tready) begin
        st       = frame_step(rx_model, s_axis_tuser, s_axis_tdata);
        rx_model = st.st;
        for (int k = 0; k < st.n; k++) pending_results.push_back(st.r[k]);
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors < 100)
            $display("%0t: unexpected result, expected none actual tdata %h tuser %0d tlast %0d",
                     $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          e = pending_results.pop_front();
          check_field("out_kind", e.out_kind, m_axis_tuser);
          check_field("reply_byte", e.reply_byte, m_axis_tdata[7:0]);
          check_field("group_id", e.group_id, m_axis_tdata[15:8]);
          check_field("command_code", e.command_code, m_axis_tdata[23:16]);
          check_field("payload_length", e.payload_length, m_axis_tdata[27:24]);
          check_field("header_checksum", e.header_checksum, m_axis_tdata[35:28]);
          check_field("payload_byte", e.payload_byte, m_axis_tdata[43:36]);
          check_field("payload_index", e.payload_index, m_axis_tdata[46:44]);
          check_field("last", e.last, m_axis_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_IDLE_LIMIT) begin
      rx_model.limit   = data[15:0];
      gen_shadow.limit = data[15:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // all items taken and all results seen, then room for a silent trailing item
  task automatic drain();
    while (rx_queue.size() != 0 || offered || pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    int unsigned limits [5];
    int          phase_start;
    limits[0] = 0;
    limits[1] = 2;
    limits[2] = 65535;
    limits[3] = $urandom_range(3, 65534);
    limits[4] = 1;

    rx_model       = '0;
    rx_model.ph    = PH_HEADER;
    rx_model.limit = IDLE_LIMIT_RESET;
    gen_shadow     = rx_model;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset idle limit
    // zero length frame with an idle tick inside the header
    add_rx(1'b0, 8'h00);
    add_rx(1'b1, 8'hff);
    add_rx(1'b0, 8'h00);
    add_rx(1'b0, 8'h00);
    add_rx(1'b0, 8'h00);
    // longest payload, extreme header bytes, idle tick inside the payload
    add_rx(1'b0, 8'hff);
    add_rx(1'b0, 8'hff);
    add_rx(1'b0, 8'd8);
    add_rx(1'b0, 8'h06);
    add_rx(1'b0, 8'hff);
    add_rx(1'b0, 8'h00);
    add_rx(1'b0, 8'h01);
    add_rx(1'b0, 8'h80);
    add_rx(1'b1, 8'h00);
    add_rx(1'b0, 8'h7f);
    add_rx(1'b0, 8'hfe);
    add_rx(1'b0, 8'h55);
    add_rx(1'b0, 8'haa);
    add_rx(1'b0, gen_shadow.sum);
    // length one past the maximum with a good checksum
    add_rx(1'b0, 8'h00);
    add_rx(1'b0, 8'h00);
    add_rx(1'b0, 8'd9);
    add_rx(1'b0, 8'd9);
    // payload checksum failure, then the payload again
    add_rx(1'b0, 8'h05);
    add_rx(1'b0, 8'h06);
    add_rx(1'b0, 8'h01);
    add_rx(1'b0, 8'h0c);
    add_rx(1'b0, 8'hff);
    add_rx(1'b0, 8'h00);
    add_rx(1'b0, 8'h3c);
    add_rx(1'b0, 8'h3c);
    drain();

    for (int p = 0; p < 5; p++) begin
      apb_write(ADDR_IDLE_LIMIT, limits[p]);
      @(posedge clk_i);
      calm = (p == 4);          // last stretch runs without gaps or stalls
      if (p == 1) hold_req = 1'b1;
      phase_start = rx_total;
      while (rx_total - phase_start < 56) gen_frame();
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #36ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
